// ===== rtl/lba_pkg.sv =====
// Shared widths and command/status codes for the linked block allocator.
`default_nettype none

package lba_pkg;

  // Fixed port field widths
  localparam int CFG_W     = 7;
  localparam int SLOT_W    = 4;
  localparam int LEN_W     = 7;
  localparam int STAT_W    = 2;
  localparam int BLK_OUT_W = 6;
  localparam int CNT_OUT_W = 7;

  // Command code (the other value means delete)
  localparam logic CMD_CREATE = 1'b0;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_SLOT_USED = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/lba_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
`default_nettype none

module lba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/linked_block_allocator.sv =====
// Linked block allocator: free bitmap, link table and slot table in synchronous RAMs.
// Create: an accept state, a bitmap scan up to the highest block taken, then a result state;
//   a refused or zero-length create goes straight to the result. Delete: accept, slot load,
//   chain walk over the file's blocks, result. One item at a time; the scan and the chain walk
// handle one block per cycle. After reset a clearing sweep marks all blocks free before the
// first item; after a config write a recount runs before the next item.
`default_nettype none

module linked_block_allocator #(
  parameter int MAX_BLOCKS = 64,
  parameter int MAX_FILES  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd,
  input  logic [lba_pkg::SLOT_W-1:0]     file_slot,
  input  logic [lba_pkg::LEN_W-1:0]      length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lba_pkg::STAT_W-1:0]     status,
  output logic [lba_pkg::BLK_OUT_W-1:0]  head_blk,
  output logic [lba_pkg::BLK_OUT_W-1:0]  tail_blk,
  output logic [lba_pkg::CNT_OUT_W-1:0]  free_blocks,
  input  logic                           cfg_we,
  input  logic [lba_pkg::CFG_W-1:0]      cfg_data
);

  import lba_pkg::*;

  localparam int BW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int SW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int EW = 2 * BW + LEN_W;
  localparam logic [BW-1:0] LAST_BLK = BW'(MAX_BLOCKS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_COUNT = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DLOAD = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // Control state
  logic [2:0]           state;
  logic [BW-1:0]        chk;        // block whose bitmap bit is on the RAM output
  logic [CW-1:0]        lim;        // managed block count
  logic [CW-1:0]        free_cnt;   // free blocks below lim
  logic                 recount;
  logic [LEN_W-1:0]     remain;
  logic                 first;
  logic [MAX_FILES-1:0] slot_valid;

  // Per-item working registers
  logic [BW-1:0]        prev;
  logic [BW-1:0]        sb_r;
  logic [LEN_W-1:0]     len_r;
  logic [SW-1:0]        slot_r;
  logic [STAT_W-1:0]    res_status;
  logic [BW-1:0]        res_sb;
  logic [BW-1:0]        res_eb;

  // RAM ports
  logic          fm_we;
  logic [BW-1:0] fm_waddr;
  logic [0:0]    fm_wdata;
  logic [BW-1:0] fm_raddr;
  logic [0:0]    fm_rdata;
  logic          lk_we;
  logic [BW-1:0] lk_waddr;
  logic [BW-1:0] lk_wdata;
  logic [BW-1:0] lk_raddr;
  logic [BW-1:0] lk_rdata;
  logic          sl_we;
  logic [SW-1:0] sl_waddr;
  logic [EW-1:0] sl_wdata;
  logic [EW-1:0] sl_rdata;

  logic          accept;
  logic [31:0]   slot_ext;
  logic [SW-1:0] slot_idx;
  logic          slot_bad;
  logic          slot_used;
  logic          short_space;
  logic [BW-1:0] walk_b;
  logic [31:0]   cfg_ext;
  logic [31:0]   sb_ext;
  logic [31:0]   eb_ext;
  logic [31:0]   cnt_ext;

  assign accept      = in_valid && in_ready;
  assign in_ready    = (state == S_IDLE) && !recount;
  assign slot_ext    = 32'(file_slot);
  assign slot_idx    = slot_ext[SW-1:0];
  assign slot_bad    = slot_ext >= MAX_FILES;
  assign slot_used   = slot_bad || slot_valid[slot_idx];
  assign short_space = 32'(length) > 32'(free_cnt);
  assign walk_b      = first ? sb_r : lk_rdata;
  assign cfg_ext     = 32'(cfg_data);
  assign sb_ext      = 32'(res_sb);
  assign eb_ext      = 32'(res_eb);
  assign cnt_ext     = 32'(free_cnt);

  // Free bitmap: one bit per block, 1 = free
  lba_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_free_map (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  // Link table: next block of each chain
  lba_ram #(.WIDTH(BW), .DEPTH(MAX_BLOCKS)) u_link (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  // Slot table: {start, end, length} per file slot
  lba_ram #(.WIDTH(EW), .DEPTH(MAX_FILES)) u_slots (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .raddr (slot_idx),
    .rdata (sl_rdata)
  );

  // RAM port control
  always_comb begin
    fm_raddr = (state == S_IDLE) ? '0 : chk + 1'b1;
    fm_we    = 1'b0;
    fm_waddr = chk;
    fm_wdata = 1'b0;
    lk_we    = 1'b0;
    lk_waddr = prev;
    lk_wdata = chk;
    lk_raddr = walk_b;
    sl_we    = 1'b0;
    sl_waddr = slot_r;
    sl_wdata = {(first ? chk : sb_r), chk, len_r};
    case (state)
      S_CLEAR: begin
        fm_we    = 1'b1;
        fm_wdata = 1'b1;
      end
      S_IDLE: begin
        // zero-length create: record an empty file right away
        if (accept && cmd == CMD_CREATE && !slot_used && !short_space && length == '0) begin
          sl_we    = 1'b1;
          sl_waddr = slot_idx;
          sl_wdata = '0;
        end
      end
      S_SCAN: begin
        if (fm_rdata[0]) begin
          fm_we = 1'b1;
          lk_we = !first;
          sl_we = (remain == LEN_W'(1));
        end
      end
      S_WALK: begin
        fm_we    = 1'b1;
        fm_waddr = walk_b;
        fm_wdata = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      chk        <= '0;
      lim        <= CW'(MAX_BLOCKS);
      free_cnt   <= CW'(MAX_BLOCKS);
      recount    <= 1'b0;
      remain     <= '0;
      first      <= 1'b0;
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      // S_OUT reloads the result register itself
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        // mark every block free after reset
        S_CLEAR: begin
          chk <= chk + 1'b1;
          if (chk == LAST_BLK) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            slot_r <= slot_idx;
            len_r  <= length;
            chk    <= '0;
            first  <= 1'b1;
            remain <= length;
            res_sb <= '0;
            res_eb <= '0;
            if (cmd == CMD_CREATE) begin
              if (slot_used) begin
                res_status <= ST_SLOT_USED;
                state      <= S_OUT;
              end else if (short_space) begin
                res_status <= ST_NO_SPACE;
                state      <= S_OUT;
              end else if (length == '0) begin
                slot_valid[slot_idx] <= 1'b1;
                res_status           <= ST_OK;
                state                <= S_OUT;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              if (slot_bad || !slot_valid[slot_idx]) begin
                res_status <= ST_NOT_FOUND;
                state      <= S_OUT;
              end else begin
                state <= S_DLOAD;
              end
            end
          end else if (recount && !cfg_we) begin
            recount  <= 1'b0;
            free_cnt <= '0;
            chk      <= '0;
            state    <= S_COUNT;
          end
        end
        // count free blocks below the managed limit
        S_COUNT: begin
          if (fm_rdata[0] && 32'(chk) < 32'(lim)) begin
            free_cnt <= free_cnt + 1'b1;
          end
          chk <= chk + 1'b1;
          if (chk == LAST_BLK) begin
            state <= S_IDLE;
          end
        end
        // take free blocks in ascending order; enough exist below lim
        S_SCAN: begin
          chk <= chk + 1'b1;
          if (fm_rdata[0]) begin
            first    <= 1'b0;
            prev     <= chk;
            free_cnt <= free_cnt - 1'b1;
            if (first) begin
              sb_r <= chk;
            end
            if (remain == LEN_W'(1)) begin
              slot_valid[slot_r] <= 1'b1;
              res_status         <= ST_OK;
              res_sb             <= first ? chk : sb_r;
              res_eb             <= chk;
              state              <= S_OUT;
            end else begin
              remain <= remain - 1'b1;
            end
          end
        end
        // slot entry is on the RAM output
        S_DLOAD: begin
          sb_r       <= sl_rdata[EW-1 -: BW];
          res_sb     <= sl_rdata[EW-1 -: BW];
          res_eb     <= sl_rdata[LEN_W +: BW];
          remain     <= sl_rdata[LEN_W-1:0];
          res_status <= ST_OK;
          first      <= 1'b1;
          if (sl_rdata[LEN_W-1:0] == '0) begin
            slot_valid[slot_r] <= 1'b0;
            state              <= S_OUT;
          end else begin
            state <= S_WALK;
          end
        end
        // free one chain block per cycle, following the link RAM output
        S_WALK: begin
          first <= 1'b0;
          if (32'(walk_b) < 32'(lim)) begin
            free_cnt <= free_cnt + 1'b1;
          end
          if (remain == LEN_W'(1)) begin
            slot_valid[slot_r] <= 1'b0;
            state              <= S_OUT;
          end else begin
            remain <= remain - 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            head_blk    <= sb_ext[BLK_OUT_W-1:0];
            tail_blk    <= eb_ext[BLK_OUT_W-1:0];
            free_blocks <= cnt_ext[CNT_OUT_W-1:0];
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // config write: clamp and schedule a recount of free blocks
      if (cfg_we) begin
        lim     <= (cfg_ext > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : cfg_ext[CW-1:0];
        recount <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_free_le_lim: assert property (@(posedge clk) disable iff (rst)
    !recount |-> 32'(free_cnt) <= 32'(lim))
    else $error("free count above managed block count");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !recount) |-> 32'(chk) < 32'(lim))
    else $error("bitmap scan ran past managed blocks");

  a_remain_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_WALK) |-> remain != '0)
    else $error("block counter empty while scanning or walking");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second item taken while one is in progress");
`endif

endmodule

`default_nettype wire
